FILE: design/mlfq_pkg.sv
// Shared types, codes and defaults of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int SLOT_COUNT_DEF  = 64;
  localparam int LEVEL_COUNT_DEF = 5;
  localparam int WAIT_W          = 16;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
  localparam logic [15:0] AGE_LIMIT_RST  = 16'd30;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Request codes.
  localparam logic [2:0] REQ_ADMIT   = 3'd0;
  localparam logic [2:0] REQ_WAKE    = 3'd1;
  localparam logic [2:0] REQ_TICK    = 3'd2;
  localparam logic [2:0] REQ_PICK    = 3'd3;
  localparam logic [2:0] REQ_RELEASE = 3'd4;
  localparam logic [2:0] REQ_RETIRE  = 3'd5;

  // Slot status codes.
  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_SLEEP = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [5:0] slot_id;
    logic       still_runnable;
    logic       quantum_expired;
  } in_req_t;

  typedef struct packed {
    logic       accepted;
    logic       pick_valid;
    logic [5:0] picked_slot;
    logic [2:0] picked_level;
  } out_rsp_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_CHECK,
    FSM_TICK,
    FSM_SC_RQ,
    FSM_SC_RS,
    FSM_SC_WR,
    FSM_PK_SEL,
    FSM_PK_RS,
    FSM_PK_WR,
    FSM_RESP
  } fsm_t;

endpackage

FILE: design/mlfq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/mlfq_process_scheduler_top.sv
// Top level of the multilevel feedback queue process scheduler with aging.
`timescale 1ns / 1ps
// Usage: requests arrive on the in_ channel (valid/ready) as an in_req_t and
// each request produces exactly one response on the out_ channel as an
// out_rsp_t. A request codes admit, wake, tick, pick, release or retire.
// The block handles one request at a time; in_ready is high only while the
// sequencer is idle. Admit, wake, release and a retire of a non-queued slot
// read the slot state in a check step (if the slot is in range or, for a
// release, a slot runs) before the response is registered; a pick while a
// slot runs and an unused code go straight to the response; a tick walks
// all SLOT_COUNT slots through the slot-state RAM; a pick runs the aging
// pass over every queued slot, each with a queue read, a slot read and a
// write back, and closes each level, then dequeues the picked slot; a
// retire of a queued slot runs the same compaction pass. The single read
// port of the queue RAM and of the slot-state RAM makes these steps serial.
// The age_limit register sits at byte address 0 of the cfg_ APB port.
// Reset (rst_n low, synchronous) empties all queues, marks every slot free
// and sets age_limit to 30; slot state reads as zero until first written.
// The response is held in an output register; when the receiver stalls, the
// next request is still accepted and finished, then waits for that register.
module mlfq_process_scheduler_top
  import mlfq_pkg::*;
#(
  parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_rsp_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int CW  = SW + 1;
  localparam int LW  = $clog2(LEVEL_COUNT);
  localparam int QAW = LW + SW;
  localparam int QDEPTH = LEVEL_COUNT * (2 ** SW);
  localparam int SWW = 2 + LW + WAIT_W;
  localparam logic [CW-1:0] N_C = CW'(SLOT_COUNT);
  localparam logic [LW-1:0] LV_LAST = LW'(LEVEL_COUNT - 1);

  // Ring position (head + off) modulo SLOT_COUNT; both operands stay below it.
  function automatic logic [SW-1:0] qpos(input logic [SW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = {2'b00, head} + {1'b0, off};
    if (sum >= {1'b0, N_C}) begin
      sum = sum - {1'b0, N_C};
    end
    return sum[SW-1:0];
  endfunction

  fsm_t st_r, st_nxt;

  in_req_t        req_r, req_nxt;
  logic [15:0]    age_limit_r;
  logic [SW-1:0]  head_r [LEVEL_COUNT];
  logic [SW-1:0]  head_nxt [LEVEL_COUNT];
  logic [CW-1:0]  cnt_r [LEVEL_COUNT];
  logic [CW-1:0]  cnt_nxt [LEVEL_COUNT];
  logic           run_vld_r, run_vld_nxt;
  logic [SW-1:0]  run_slot_r, run_slot_nxt;
  logic           vld_r [SLOT_COUNT];
  logic           s_vld_q_r;

  // Compaction scan state.
  logic [LW-1:0]  lv_r, lv_nxt;
  logic [CW-1:0]  k_r, k_nxt, n_r, n_nxt, w_r, w_nxt, up_cnt_r, up_cnt_nxt;
  logic [SW-1:0]  cur_head_r, cur_head_nxt, up_head_r, up_head_nxt;
  logic           scan_age_r, scan_age_nxt;
  logic [SW-1:0]  e_r, e_nxt;

  // Tick sweep state.
  logic [CW-1:0]  idx_r, idx_nxt;
  logic           tpend_r, tpend_nxt;
  logic [SW-1:0]  tidx_r, tidx_nxt;

  // Pending response.
  logic           res_acc_r, res_acc_nxt, res_pv_r, res_pv_nxt;
  logic [SW-1:0]  res_ps_r, res_ps_nxt;
  logic [LW-1:0]  res_pl_r, res_pl_nxt;
  logic           out_valid_r;
  out_rsp_t       out_data_r;

  // RAM ports.
  logic           q_we;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [SW-1:0]  q_wdata, q_rdata;
  logic           s_we;
  logic [SW-1:0]  s_waddr, s_raddr;
  logic [SWW-1:0] s_wdata, s_rdata, s_word;

  logic [1:0]        rd_stat;
  logic [LW-1:0]     rd_lvl;
  logic [WAIT_W-1:0] rd_wait;

  logic           accept;
  logic [SW-1:0]  sid;
  logic           sid_ok;
  logic           retire_scan;
  logic           lv_done;
  logic           pk_found;
  logic [LW-1:0]  pk_lv;
  logic           resp_free;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (st_r == FSM_IDLE);
  assign sid       = SW'(in_data.slot_id);
  assign sid_ok    = 32'(in_data.slot_id) < SLOT_COUNT;
  assign resp_free = !out_valid_r || out_ready;

  assign s_word  = s_vld_q_r ? s_rdata : '0;
  assign rd_stat = s_word[SWW-1 -: 2];
  assign rd_lvl  = s_word[WAIT_W +: LW];
  assign rd_wait = s_word[WAIT_W-1:0];

  assign retire_scan = (req_r.req_type == REQ_RETIRE) && (rd_stat == ST_READY);
  assign lv_done     = (k_r >= n_r);

  // Most urgent non-empty level.
  always_comb begin
    pk_found = 1'b0;
    pk_lv    = '0;
    for (int l = LEVEL_COUNT - 1; l >= 0; l--) begin
      if (cnt_r[l] != '0) begin
        pk_found = 1'b1;
        pk_lv    = LW'(l);
      end
    end
  end

  mlfq_ram #(.WIDTH(SW), .DEPTH(QDEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  mlfq_ram #(.WIDTH(SWW), .DEPTH(SLOT_COUNT)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FSM_IDLE: begin
        if (accept) begin
          case (in_data.req_type)
            REQ_ADMIT, REQ_WAKE, REQ_RETIRE: st_nxt = sid_ok ? FSM_CHECK : FSM_RESP;
            REQ_RELEASE: st_nxt = run_vld_r ? FSM_CHECK : FSM_RESP;
            REQ_TICK:    st_nxt = FSM_TICK;
            REQ_PICK:    st_nxt = run_vld_r ? FSM_RESP : FSM_SC_RQ;
            default:     st_nxt = FSM_RESP;
          endcase
        end
      end
      FSM_CHECK:  st_nxt = retire_scan ? FSM_SC_RQ : FSM_RESP;
      FSM_TICK:   st_nxt = (idx_r == N_C) ? FSM_RESP : FSM_TICK;
      FSM_SC_RQ: begin
        if (!lv_done) begin
          st_nxt = FSM_SC_RS;
        end else if (lv_r == LV_LAST) begin
          st_nxt = scan_age_r ? FSM_PK_SEL : FSM_RESP;
        end
      end
      FSM_SC_RS:  st_nxt = FSM_SC_WR;
      FSM_SC_WR:  st_nxt = FSM_SC_RQ;
      FSM_PK_SEL: st_nxt = pk_found ? FSM_PK_RS : FSM_RESP;
      FSM_PK_RS:  st_nxt = FSM_PK_WR;
      FSM_PK_WR:  st_nxt = FSM_RESP;
      FSM_RESP:   st_nxt = resp_free ? FSM_IDLE : FSM_RESP;
      default:    st_nxt = FSM_IDLE;
    endcase
  end

  // Datapath and RAM control.
  always_comb begin
    logic          eq_en;
    logic [LW-1:0] eq_lv;
    logic [SW-1:0] eq_id;
    logic [LW:0]   lvl_up;
    logic [LW-1:0] nl;
    logic [WAIT_W-1:0] nw;

    eq_en = 1'b0;
    eq_lv = '0;
    eq_id = '0;
    lvl_up = '0;
    nl = '0;
    nw = '0;

    req_nxt      = req_r;
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    run_vld_nxt  = run_vld_r;
    run_slot_nxt = run_slot_r;
    lv_nxt       = lv_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    w_nxt        = w_r;
    up_cnt_nxt   = up_cnt_r;
    cur_head_nxt = cur_head_r;
    up_head_nxt  = up_head_r;
    scan_age_nxt = scan_age_r;
    e_nxt        = e_r;
    idx_nxt      = idx_r;
    tpend_nxt    = tpend_r;
    tidx_nxt     = tidx_r;
    res_acc_nxt  = res_acc_r;
    res_pv_nxt   = res_pv_r;
    res_ps_nxt   = res_ps_r;
    res_pl_nxt   = res_pl_r;

    q_we    = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    q_raddr = '0;
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;

    case (st_r)
      FSM_IDLE: begin
        s_raddr = (in_data.req_type == REQ_RELEASE) ? run_slot_r : sid;
        if (accept) begin
          req_nxt      = in_data;
          // A tick always takes effect, and so does a pick with nothing running.
          res_acc_nxt  = (in_data.req_type == REQ_TICK) ||
                         ((in_data.req_type == REQ_PICK) && !run_vld_r);
          res_pv_nxt   = 1'b0;
          res_ps_nxt   = '0;
          res_pl_nxt   = '0;
          idx_nxt      = '0;
          tpend_nxt    = 1'b0;
          scan_age_nxt = 1'b1;
          lv_nxt       = '0;
          k_nxt        = '0;
          w_nxt        = '0;
          cur_head_nxt = head_r[0];
          n_nxt        = cnt_r[0];
        end
      end

      FSM_CHECK: begin
        case (req_r.req_type)
          REQ_ADMIT: begin
            if (rd_stat == ST_FREE) begin
              s_we    = 1'b1;
              s_waddr = SW'(req_r.slot_id);
              s_wdata = {ST_READY, {LW{1'b0}}, {WAIT_W{1'b0}}};
              eq_en   = 1'b1;
              eq_lv   = '0;
              eq_id   = SW'(req_r.slot_id);
              res_acc_nxt = 1'b1;
            end
          end
          REQ_WAKE: begin
            if (rd_stat == ST_SLEEP) begin
              s_we    = 1'b1;
              s_waddr = SW'(req_r.slot_id);
              s_wdata = {ST_READY, rd_lvl, rd_wait};
              eq_en   = 1'b1;
              eq_lv   = rd_lvl;
              eq_id   = SW'(req_r.slot_id);
              res_acc_nxt = 1'b1;
            end
          end
          REQ_RELEASE: begin
            // Expired slice: demote one level, bounded by the last level.
            lvl_up = {1'b0, rd_lvl} + 1'b1;
            nl = rd_lvl;
            nw = rd_wait;
            if (req_r.quantum_expired) begin
              if (rd_lvl != LV_LAST) begin
                nl = lvl_up[LW-1:0];
              end
              nw = '0;
            end
            s_we    = 1'b1;
            s_waddr = run_slot_r;
            s_wdata = {(req_r.still_runnable ? ST_READY : ST_SLEEP), nl, nw};
            eq_en   = req_r.still_runnable;
            eq_lv   = nl;
            eq_id   = run_slot_r;
            run_vld_nxt = 1'b0;
            res_acc_nxt = 1'b1;
          end
          REQ_RETIRE: begin
            if (rd_stat != ST_FREE) begin
              s_we    = 1'b1;
              s_waddr = SW'(req_r.slot_id);
              s_wdata = '0;
              if (run_vld_r && (run_slot_r == SW'(req_r.slot_id))) begin
                run_vld_nxt = 1'b0;
              end
              res_acc_nxt  = 1'b1;
              scan_age_nxt = 1'b0;
              lv_nxt       = '0;
              k_nxt        = '0;
              w_nxt        = '0;
              cur_head_nxt = head_r[0];
              n_nxt        = cnt_r[0];
            end
          end
          default: ;
        endcase
      end

      FSM_TICK: begin
        if (idx_r < N_C) begin
          s_raddr   = idx_r[SW-1:0];
          tpend_nxt = 1'b1;
          tidx_nxt  = idx_r[SW-1:0];
          idx_nxt   = idx_r + 1'b1;
        end else begin
          tpend_nxt = 1'b0;
        end
        if (tpend_r && (rd_stat != ST_FREE) && (rd_stat != ST_RUN) &&
            (rd_wait != WAIT_MAX)) begin
          s_we    = 1'b1;
          s_waddr = tidx_r;
          s_wdata = {rd_stat, rd_lvl, rd_wait + 1'b1};
        end
      end

      FSM_SC_RQ: begin
        if (!lv_done) begin
          q_raddr = {lv_r, qpos(cur_head_r, k_r)};
        end else begin
          // Close the level: the level above gets its final count, and this
          // level becomes the promotion target of the next one.
          if (lv_r != '0) begin
            cnt_nxt[lv_r - 1'b1] = up_cnt_r;
          end
          if (lv_r == LV_LAST) begin
            cnt_nxt[lv_r] = w_r;
          end else begin
            up_head_nxt  = cur_head_r;
            up_cnt_nxt   = w_r;
            lv_nxt       = lv_r + 1'b1;
            cur_head_nxt = head_r[lv_r + 1'b1];
            n_nxt        = cnt_r[lv_r + 1'b1];
            k_nxt        = '0;
            w_nxt        = '0;
          end
        end
      end

      FSM_SC_RS: begin
        e_nxt   = q_rdata;
        s_raddr = q_rdata;
      end

      FSM_SC_WR: begin
        k_nxt = k_r + 1'b1;
        if (scan_age_r && (lv_r != '0) && (rd_wait > age_limit_r)) begin
          q_we       = 1'b1;
          q_waddr    = {lv_r - 1'b1, qpos(up_head_r, up_cnt_r)};
          q_wdata    = e_r;
          up_cnt_nxt = up_cnt_r + 1'b1;
          s_we       = 1'b1;
          s_waddr    = e_r;
          s_wdata    = {rd_stat, lv_r - 1'b1, {WAIT_W{1'b0}}};
        end else if (scan_age_r || (e_r != SW'(req_r.slot_id))) begin
          q_we    = 1'b1;
          q_waddr = {lv_r, qpos(cur_head_r, w_r)};
          q_wdata = e_r;
          w_nxt   = w_r + 1'b1;
        end
      end

      FSM_PK_SEL: begin
        if (pk_found) begin
          q_raddr = {pk_lv, head_r[pk_lv]};
          head_nxt[pk_lv] = qpos(head_r[pk_lv], CW'(1));
          cnt_nxt[pk_lv]  = cnt_r[pk_lv] - 1'b1;
          res_pl_nxt      = pk_lv;
        end
      end

      FSM_PK_RS: begin
        e_nxt   = q_rdata;
        s_raddr = q_rdata;
      end

      FSM_PK_WR: begin
        s_we         = 1'b1;
        s_waddr      = e_r;
        s_wdata      = {ST_RUN, rd_lvl, rd_wait};
        run_vld_nxt  = 1'b1;
        run_slot_nxt = e_r;
        res_pv_nxt   = 1'b1;
        res_ps_nxt   = e_r;
      end

      default: ;
    endcase

    // Tail insert shared by admit, wake and release.
    if (eq_en) begin
      q_we    = 1'b1;
      q_waddr = {eq_lv, qpos(head_r[eq_lv], cnt_r[eq_lv])};
      q_wdata = eq_id;
      cnt_nxt[eq_lv] = cnt_r[eq_lv] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= FSM_IDLE;
      run_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      tpend_r     <= 1'b0;
      age_limit_r <= AGE_LIMIT_RST;
      for (int l = 0; l < LEVEL_COUNT; l++) begin
        head_r[l] <= '0;
        cnt_r[l]  <= '0;
      end
      for (int s = 0; s < SLOT_COUNT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      st_r      <= st_nxt;
      run_vld_r <= run_vld_nxt;
      tpend_r   <= tpend_nxt;
      head_r    <= head_nxt;
      cnt_r     <= cnt_nxt;
      if (s_we) begin
        vld_r[s_waddr] <= 1'b1;
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
        age_limit_r <= cfg_pwdata[15:0];
      end
      if (st_r == FSM_RESP && resp_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    run_slot_r <= run_slot_nxt;
    lv_r       <= lv_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    w_r        <= w_nxt;
    up_cnt_r   <= up_cnt_nxt;
    cur_head_r <= cur_head_nxt;
    up_head_r  <= up_head_nxt;
    scan_age_r <= scan_age_nxt;
    e_r        <= e_nxt;
    idx_r      <= idx_nxt;
    tidx_r     <= tidx_nxt;
    res_acc_r  <= res_acc_nxt;
    res_pv_r   <= res_pv_nxt;
    res_ps_r   <= res_ps_nxt;
    res_pl_r   <= res_pl_nxt;
    s_vld_q_r  <= vld_r[s_raddr];
    if (st_r == FSM_RESP && resp_free) begin
      out_data_r.accepted     <= res_acc_r;
      out_data_r.pick_valid   <= res_pv_r;
      out_data_r.picked_slot  <= 6'(res_ps_r);
      out_data_r.picked_level <= 3'(res_pl_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? '0 : CFG_DW'(age_limit_r);

endmodule

FILE: tb/sv/mlfq_sched_checker.sv
// Checker for the feedback queue scheduler: predicts every response and compares it.
`timescale 1ns / 1ps
module mlfq_sched_checker
  import mlfq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  in_req_t           in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  out_rsp_t          out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                pending
);

  localparam int NSLOT = SLOT_COUNT_DEF;
  localparam int NLVL  = LEVEL_COUNT_DEF;
  localparam logic [CFG_AW-1:0] ADDR_AGE_LIMIT = '0;

  logic [2:0]        slot_lvl  [NSLOT];
  logic [WAIT_W-1:0] slot_wait [NSLOT];
  logic [1:0]        slot_st   [NSLOT];
  logic              run_busy;
  logic [5:0]        run_id;
  logic [5:0]        ready_q   [NLVL][$];
  logic [15:0]       age_limit;
  out_rsp_t          rsp_expected [$];

  function automatic bit slot_queued(logic [5:0] s);
    for (int lv = 0; lv < NLVL; lv++)
      for (int k = 0; k < ready_q[lv].size(); k++)
        if (ready_q[lv][k] == s) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit queue_slot(int lv, logic [5:0] s);
    if (ready_q[lv].size() >= NSLOT || slot_queued(s)) return 1'b0;
    ready_q[lv].push_back(s);
    return 1'b1;
  endfunction

  // Promotes long-waiting slots one level; those left behind keep their order.
  function automatic void promote_aged();
    logic [5:0] kept [$];
    for (int lv = 1; lv < NLVL; lv++) begin
      kept.delete();
      for (int k = 0; k < ready_q[lv].size(); k++) begin
        logic [5:0] e;
        e = ready_q[lv][k];
        if (slot_wait[e] > age_limit && ready_q[lv-1].size() < NSLOT) begin
          ready_q[lv-1].push_back(e);
          slot_lvl[e]  = 3'(lv - 1);
          slot_wait[e] = '0;
        end else begin
          kept.push_back(e);
        end
      end
      ready_q[lv] = kept;
    end
  endfunction

  function automatic out_rsp_t schedule_request(in_req_t r);
    out_rsp_t   rsp;
    logic [5:0] s;
    logic [5:0] kept [$];
    rsp = '0;
    s   = r.slot_id;
    case (r.req_type)
      REQ_ADMIT: begin
        if (slot_st[s] == ST_FREE) begin
          slot_lvl[s]  = '0;
          slot_wait[s] = '0;
          if (queue_slot(0, s)) begin
            slot_st[s]   = ST_READY;
            rsp.accepted = 1'b1;
          end
        end
      end
      REQ_WAKE: begin
        if (slot_st[s] == ST_SLEEP && queue_slot(slot_lvl[s] % NLVL, s)) begin
          slot_st[s]   = ST_READY;
          rsp.accepted = 1'b1;
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_st[i] != ST_FREE && slot_st[i] != ST_RUN && slot_wait[i] != WAIT_MAX)
            slot_wait[i]++;
        rsp.accepted = 1'b1;
      end
      REQ_PICK: begin
        if (!run_busy) begin
          promote_aged();
          rsp.accepted = 1'b1;
          for (int lv = 0; lv < NLVL; lv++) begin
            if (!rsp.pick_valid && ready_q[lv].size() > 0) begin
              s = ready_q[lv].pop_front();
              slot_st[s]       = ST_RUN;
              run_busy         = 1'b1;
              run_id           = s;
              rsp.pick_valid   = 1'b1;
              rsp.picked_slot  = s;
              rsp.picked_level = 3'(lv);
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (run_busy) begin
          s            = run_id;
          run_busy     = 1'b0;
          rsp.accepted = 1'b1;
          if (r.quantum_expired) begin
            if (slot_lvl[s] + 1 < NLVL) slot_lvl[s]++;
            slot_wait[s] = '0;
          end
          slot_st[s] = ST_SLEEP;
          if (r.still_runnable && queue_slot(slot_lvl[s] % NLVL, s)) slot_st[s] = ST_READY;
        end
      end
      REQ_RETIRE: begin
        if (slot_st[s] != ST_FREE) begin
          for (int lv = 0; lv < NLVL; lv++) begin
            kept.delete();
            for (int k = 0; k < ready_q[lv].size(); k++)
              if (ready_q[lv][k] != s) kept.push_back(ready_q[lv][k]);
            ready_q[lv] = kept;
          end
          if (run_busy && run_id == s) run_busy = 1'b0;
          slot_st[s]   = ST_FREE;
          slot_lvl[s]  = '0;
          slot_wait[s] = '0;
          rsp.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_lvl[i]  = '0;
        slot_wait[i] = '0;
        slot_st[i]   = ST_FREE;
      end
      for (int lv = 0; lv < NLVL; lv++) ready_q[lv].delete();
      run_busy = 1'b0;
      run_id   = '0;
      age_limit = AGE_LIMIT_RST;
      rsp_expected.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == ADDR_AGE_LIMIT)
        age_limit = cfg_pwdata[15:0];
      if (in_valid && in_ready)
        rsp_expected.push_back(schedule_request(in_data));
      if (out_valid && out_ready) begin
        if (rsp_expected.size() == 0) begin
          $display("%0t: response with none expected, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = rsp_expected.pop_front();
          if (want.accepted !== out_data.accepted || want.pick_valid !== out_data.pick_valid
              || want.picked_slot !== out_data.picked_slot
              || want.picked_level !== out_data.picked_level) begin
            $display("%0t: response mismatch, expected %p actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= rsp_expected.size();
  end

endmodule

FILE: tb/sv/mlfq_process_scheduler_top_tb.sv
// Testbench top of the feedback queue scheduler: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module mlfq_process_scheduler_top_tb;
  import mlfq_pkg::*;

  // Request codes the block must ignore.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [CFG_AW-1:0] ADDR_AGE_LIMIT = '0;
  // The limit covers a pick that ages every slot while all are queued, plus stalls.
  localparam int STALL_LIMIT = 20000;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  in_req_t           in_data     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  out_rsp_t          out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  mlfq_process_scheduler_top dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  mlfq_sched_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver drops ready at random, at the rate the current phase sets.
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // The watchdog ends a run in which neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("mlfq_process_scheduler_top_tb: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sends one request. Valid stays high between back-to-back requests and is
  // lowered only when the sender decides to idle first. The handshake is
  // sampled at the falling edge, where in_ready is settled.
  task automatic send_request(input in_req_t r);
    int gap;
    bit fire;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(negedge clk);
      fire = in_ready;
      @(posedge clk);
    end while (!fire);
  endtask

  task automatic send_fields(input logic [2:0] op, input logic [5:0] slot,
                             input logic runnable, input logic expired);
    in_req_t r;
    r.req_type        = op;
    r.slot_id         = slot;
    r.still_runnable  = runnable;
    r.quantum_expired = expired;
    send_request(r);
  endtask

  // Drains every outstanding response before the register is touched. It first
  // waits for the checker's pending count to take in the last request sent.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // APB write: setup cycle, then the access cycle that commits the data.
  task automatic write_age_limit(input logic [15:0] value);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_AGE_LIMIT;
    cfg_pwdata  <= {16'h0, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Random mix weighted toward admits, ticks and picks so the queues fill up
  // and aging kicks in. Retires stay rare so slots live long enough to age.
  task automatic random_phase(input int count);
    int p;
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      p = $urandom_range(0, 99);
      if (p < 20)      op = REQ_ADMIT;
      else if (p < 34) op = REQ_WAKE;
      else if (p < 56) op = REQ_TICK;
      else if (p < 77) op = REQ_PICK;
      else if (p < 93) op = REQ_RELEASE;
      else if (p < 98) op = REQ_RETIRE;
      else if (p < 99) op = REQ_UNUSED_LO;
      else             op = REQ_UNUSED_HI;
      send_fields(op, 6'($urandom_range(0, 63)), 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset age limit.
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);  // pick with all queues empty
    send_fields(REQ_RELEASE,   6'd0,  1'b1, 1'b1);  // release with nothing running
    send_fields(REQ_ADMIT,     6'd0,  1'b0, 1'b0);
    send_fields(REQ_ADMIT,     6'd63, 1'b1, 1'b1);
    send_fields(REQ_ADMIT,     6'd63, 1'b0, 1'b0);  // admit of a slot already queued
    send_fields(REQ_WAKE,      6'd0,  1'b0, 1'b0);  // wake of a slot that is not asleep
    send_fields(REQ_TICK,      6'd0,  1'b0, 1'b0);
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);  // pick while a slot runs
    send_fields(REQ_RELEASE,   6'd0,  1'b1, 1'b1);  // demoted and requeued
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);
    send_fields(REQ_RELEASE,   6'd0,  1'b0, 1'b1);  // demoted and put to sleep
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);
    send_fields(REQ_RELEASE,   6'd0,  1'b0, 1'b0);  // asleep, level kept
    send_fields(REQ_WAKE,      6'd63, 1'b0, 1'b0);
    send_fields(REQ_RETIRE,    6'd21, 1'b0, 1'b0);  // retire of a free slot
    send_fields(REQ_UNUSED_LO, 6'd0,  1'b0, 1'b0);
    send_fields(REQ_UNUSED_HI, 6'd63, 1'b1, 1'b1);
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);
    send_fields(REQ_RETIRE,    6'd0,  1'b0, 1'b0);  // retire of a sleeping slot
    send_fields(REQ_RETIRE,    6'd63, 1'b0, 1'b0);  // retire of the running slot

    // A zero limit promotes any queued slot that has waited one tick.
    write_age_limit(16'd0);
    send_fields(REQ_ADMIT,     6'd5,  1'b0, 1'b0);
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);
    send_fields(REQ_RELEASE,   6'd0,  1'b1, 1'b1);
    send_fields(REQ_TICK,      6'd0,  1'b0, 1'b0);
    send_fields(REQ_PICK,      6'd0,  1'b0, 1'b0);

    // Sender idles lightly, receiver stalls heavily.
    write_age_limit(16'd3);
    send_idle_pct = 26;
    recv_idle_pct = 72;
    random_phase(250);

    // The other way round, first with aging off entirely.
    write_age_limit(16'hFFFF);
    send_idle_pct = 72;
    recv_idle_pct = 26;
    random_phase(120);
    write_age_limit(16'd1);
    random_phase(130);

    // Full throughput on both sides.
    write_age_limit(16'd6);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(250);

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("mlfq_process_scheduler_top_tb: PASS");
    end else begin
      $display("mlfq_process_scheduler_top_tb: FAIL");
    end
    $finish;
  end

endmodule
